### rtl/core/yhh_pkg.sv
//------------------------------------------------------------------------------
// yhh_pkg: shared types, constants and helpers of the heading hold controller
// Holds the item codes, CORDIC sizing, the arctangent table, the queue entry
// type and the 16-bit saturation helper.
//------------------------------------------------------------------------------
package yhh_pkg;

	// Item kind codes
	localparam logic CMD_POSE = 1'b0;
	localparam logic CMD_REQ  = 1'b1;

	// Reset value of the proportional gain (unsigned Q0.16, about 5/110)
	localparam logic [15:0] GAIN_RESET = 16'd2979;

	// Default and maximum CORDIC iteration counts
	localparam int CORDIC_ITER_DEF = 16;
	localparam int ATAN_LEN        = 24;
	localparam int ATAN_IDX_W      = $clog2(ATAN_LEN);

	// CORDIC vector width and angle width (angle in Q.29)
	localparam int CORDIC_W = 36;
	localparam int ANG_W    = 34;

	localparam logic signed [ANG_W-1:0] PI_Q29 = 34'sd1686629713;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// One classified item as it travels from front to back
	typedef struct packed {
		logic               command;
		logic signed [31:0] prod_wz;
		logic signed [31:0] prod_xy;
		logic signed [31:0] prod_yy;
		logic signed [31:0] prod_zz;
		logic signed [15:0] heading_offset;
		logic signed [15:0] forward_velocity;
	} yhh_entry_t;

	// atan(2^-i) in Q.29
	function automatic logic signed [ANG_W-1:0] atan_q29(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [ANG_W-1:0] r;
		case (idx)
			5'd0:  r = 34'sd421657428;
			5'd1:  r = 34'sd248918915;
			5'd2:  r = 34'sd131521918;
			5'd3:  r = 34'sd66762579;
			5'd4:  r = 34'sd33510843;
			5'd5:  r = 34'sd16771758;
			5'd6:  r = 34'sd8387925;
			5'd7:  r = 34'sd4194219;
			5'd8:  r = 34'sd2097141;
			5'd9:  r = 34'sd1048575;
			5'd10: r = 34'sd524288;
			5'd11: r = 34'sd262144;
			5'd12: r = 34'sd131072;
			5'd13: r = 34'sd65536;
			5'd14: r = 34'sd32768;
			5'd15: r = 34'sd16384;
			5'd16: r = 34'sd8192;
			5'd17: r = 34'sd4096;
			5'd18: r = 34'sd2048;
			5'd19: r = 34'sd1024;
			5'd20: r = 34'sd512;
			5'd21: r = 34'sd256;
			5'd22: r = 34'sd128;
			5'd23: r = 34'sd64;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Clamp a wide signed value to 16 bits
	function automatic logic signed [15:0] sat16(input logic signed [ANG_W-1:0] v);
		logic signed [15:0] r;
		if (v > 34'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -34'sd32768) begin
			r = -16'sd32768;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

### rtl/core/yhh_if.sv
//------------------------------------------------------------------------------
// yhh_if: channel interfaces of the heading hold controller
// Item, result and gain write channels, each with valid/ready handshake.
//------------------------------------------------------------------------------
interface yhh_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	logic signed [15:0] heading_offset;
	logic signed [15:0] forward_velocity;

	modport source (
		output valid, command, quat_x, quat_y, quat_z, quat_w,
		       heading_offset, forward_velocity,
		input  ready
	);
	modport sink (
		input  valid, command, quat_x, quat_y, quat_z, quat_w,
		       heading_offset, forward_velocity,
		output ready
	);
endinterface

interface yhh_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] velocity_out;
	logic signed [15:0] turn_rate;
	logic signed [15:0] heading_error;

	modport source (
		output valid, velocity_out, turn_rate, heading_error,
		input  ready
	);
	modport sink (
		input  valid, velocity_out, turn_rate, heading_error,
		output ready
	);
endinterface

interface yhh_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (
		output valid, data,
		input  ready
	);
	modport sink (
		input  valid, data,
		output ready
	);
endinterface

### rtl/core/yhh_front.sv
//------------------------------------------------------------------------------
// yhh_front: item intake and classification
// Registers each accepted item, forms the quaternion products and pushes
// one queue entry per item.
//------------------------------------------------------------------------------
module yhh_front (
	input  logic                clk,
	input  logic                arst_n,
	yhh_in_if.sink              item,
	output logic                push,
	output yhh_pkg::yhh_entry_t entry,
	input  logic                full
);

	logic               valid_s1;
	logic               command_s1;
	logic signed [15:0] quat_x_s1;
	logic signed [15:0] quat_y_s1;
	logic signed [15:0] quat_z_s1;
	logic signed [15:0] quat_w_s1;
	logic signed [15:0] offset_s1;
	logic signed [15:0] velocity_s1;
	logic               accept;

	// Take a new transaction when the stage is empty or drains this cycle
	assign push       = valid_s1 && !full;
	assign item.ready = !valid_s1 || !full;
	assign accept     = item.valid && item.ready;

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1  <= item.command;
			quat_x_s1   <= item.quat_x;
			quat_y_s1   <= item.quat_y;
			quat_z_s1   <= item.quat_z;
			quat_w_s1   <= item.quat_w;
			offset_s1   <= item.heading_offset;
			velocity_s1 <= item.forward_velocity;
		end
	end

	// Form the exact Q.30 products for the yaw formula
	always_comb begin
		entry.command          = command_s1;
		entry.prod_wz          = 32'(quat_w_s1) * 32'(quat_z_s1);
		entry.prod_xy          = 32'(quat_x_s1) * 32'(quat_y_s1);
		entry.prod_yy          = 32'(quat_y_s1) * 32'(quat_y_s1);
		entry.prod_zz          = 32'(quat_z_s1) * 32'(quat_z_s1);
		entry.heading_offset   = offset_s1;
		entry.forward_velocity = velocity_s1;
	end

endmodule

### rtl/core/yhh_queue.sv
//------------------------------------------------------------------------------
// yhh_queue: short entry queue between front and back
// Decouples intake from execution so each side stalls on its own.
//------------------------------------------------------------------------------
module yhh_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  yhh_pkg::yhh_entry_t wr_entry,
	output logic                full,
	input  logic                pop,
	output yhh_pkg::yhh_entry_t rd_entry,
	output logic                empty
);

	localparam int DEPTH = yhh_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	yhh_pkg::yhh_entry_t slots_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = slots_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

### rtl/core/yhh_back.sv
//------------------------------------------------------------------------------
// yhh_back: execution of pose updates and control requests
// Runs the vectoring CORDIC for pose entries and the target, error and
// gain steps for request entries; drives the result register.
//------------------------------------------------------------------------------
module yhh_back #(
	parameter int CORDIC_ITERATIONS = yhh_pkg::CORDIC_ITER_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  yhh_pkg::yhh_entry_t head,
	input  logic                empty,
	output logic                pop,
	input  logic [15:0]         gain,
	yhh_out_if.source           result
);

	localparam int CW    = yhh_pkg::CORDIC_W;
	localparam int AW    = yhh_pkg::ANG_W;
	localparam int IW    = yhh_pkg::ATAN_IDX_W;
	localparam int CNT_W = $clog2(CORDIC_ITERATIONS);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_LOAD = 9'b000000010,
		S_PRE  = 9'b000000100,
		S_ITER = 9'b000001000,
		S_RND  = 9'b000010000,
		S_TGT  = 9'b000100000,
		S_ERR  = 9'b001000000,
		S_MUL  = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t              state_q;
	yhh_pkg::yhh_entry_t ent_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [AW-1:0] ang_q;
	logic                 zero_q;
	logic [CNT_W-1:0]     cnt_q;
	logic signed [15:0]   yaw_q;
	logic signed [15:0]   target_q;
	logic                 latched_q;
	logic signed [15:0]   err_q;
	logic signed [32:0]   prod_q;
	logic                 res_valid_q;
	logic signed [15:0]   res_vel_q;
	logic signed [15:0]   res_turn_q;
	logic signed [15:0]   res_err_q;

	logic signed [32:0]   sum_num;
	logic signed [32:0]   sum_sq;
	logic signed [33:0]   num;
	logic signed [33:0]   den;
	logic signed [CW-1:0] x_sh;
	logic signed [CW-1:0] y_sh;
	logic signed [AW-1:0] atan_i;
	logic signed [AW-1:0] ang_bias;
	logic signed [AW-1:0] ang_div;
	logic signed [AW-1:0] turn_bias;
	logic signed [AW-1:0] turn_div;
	logic                 slot_free;

	// Vector for atan2: num = 2(wz+xy), den = 1 - 2(y^2+z^2) in Q.30
	assign sum_num = 33'(ent_q.prod_wz) + 33'(ent_q.prod_xy);
	assign sum_sq  = 33'(ent_q.prod_yy) + 33'(ent_q.prod_zz);
	assign num     = {sum_num, 1'b0};
	assign den     = (34'sd1 <<< 30) - {sum_sq, 1'b0};

	// One CORDIC micro-rotation
	assign x_sh   = x_q >>> cnt_q;
	assign y_sh   = y_q >>> cnt_q;
	assign atan_i = yhh_pkg::atan_q29(IW'(cnt_q));

	// Round half up to Q3.13
	assign ang_bias  = ang_q + AW'(32768);
	assign ang_div   = ang_bias >>> 16;
	assign turn_bias = AW'(prod_q) + AW'(32768);
	assign turn_div  = turn_bias >>> 16;

	assign slot_free = !res_valid_q || result.ready;
	assign pop       = (state_q == S_IDLE) && !empty;

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			yaw_q       <= '0;
			target_q    <= '0;
			latched_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!empty) begin
						state_q <= (head.command == yhh_pkg::CMD_REQ) ? S_TGT : S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_PRE;
				end
				S_PRE: begin
					cnt_q   <= '0;
					state_q <= S_ITER;
				end
				S_ITER: begin
					if (cnt_q == CNT_W'(CORDIC_ITERATIONS - 1)) begin
						state_q <= S_RND;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_RND: begin
					yaw_q   <= zero_q ? '0 : yhh_pkg::sat16(ang_div);
					state_q <= S_IDLE;
				end
				S_TGT: begin
					if (!latched_q) begin
						target_q  <= yhh_pkg::sat16(AW'(ent_q.heading_offset) + AW'(yaw_q));
						latched_q <= 1'b1;
					end
					state_q <= S_ERR;
				end
				S_ERR: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (!empty) begin
					ent_q <= head;
				end
			end
			S_LOAD: begin
				x_q <= CW'(den);
				y_q <= CW'(num);
			end
			S_PRE: begin
				// Turn a left-half vector by pi first
				zero_q <= (x_q == '0) && (y_q == '0);
				if (x_q < 0) begin
					ang_q <= (y_q >= 0) ? yhh_pkg::PI_Q29 : -yhh_pkg::PI_Q29;
					x_q   <= -x_q;
					y_q   <= -y_q;
				end else begin
					ang_q <= '0;
				end
			end
			S_ITER: begin
				if (y_q > 0) begin
					x_q   <= x_q + y_sh;
					y_q   <= y_q - x_sh;
					ang_q <= ang_q + atan_i;
				end else begin
					x_q   <= x_q - y_sh;
					y_q   <= y_q + x_sh;
					ang_q <= ang_q - atan_i;
				end
			end
			S_ERR: begin
				err_q <= yhh_pkg::sat16(AW'(target_q) - AW'(yaw_q));
			end
			S_MUL: begin
				prod_q <= 33'($signed({1'b0, gain})) * 33'(err_q);
			end
			S_OUT: begin
				if (slot_free) begin
					res_vel_q  <= ent_q.forward_velocity;
					res_turn_q <= yhh_pkg::sat16(turn_div);
					res_err_q  <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid         = res_valid_q;
	assign result.velocity_out  = res_vel_q;
	assign result.turn_rate     = res_turn_q;
	assign result.heading_error = res_err_q;

endmodule

### rtl/core/yaw_heading_hold_p_controller.sv
//------------------------------------------------------------------------------
// yaw_heading_hold_p_controller: proportional heading hold from quaternion yaw
// Converts pose quaternions to yaw with a vectoring CORDIC and answers each
// control request with velocity, turn rate and heading error.
//
//   channel  dir  handshake      payload
//   item     in   valid/ready    command, quat_x/y/z/w, heading_offset,
//                                forward_velocity
//   result   out  valid/ready    velocity_out, turn_rate, heading_error
//   cfg      in   valid/ready    data (turn_gain, always ready)
//
// Back end steps for a pose: load, pre-rotation, the CORDIC iterations on the
// single shared rotation stage, rounding; request: target, error, gain, output.
// Intake takes an item per cycle until the intake stage and the two-entry
// queue fill.
// Reset (arst_n low) clears yaw, target, latch flag and all valids; gain
// returns to its reset value. A stalled result holds the back end in its
// output step while the front keeps filling the queue.
//------------------------------------------------------------------------------
module yaw_heading_hold_p_controller #(
	parameter int CORDIC_ITERATIONS = yhh_pkg::CORDIC_ITER_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	yhh_in_if.sink     item,
	yhh_out_if.source  result,
	yhh_cfg_if.sink    cfg
);

	logic                push;
	logic                pop;
	logic                full;
	logic                empty;
	yhh_pkg::yhh_entry_t wr_entry;
	yhh_pkg::yhh_entry_t rd_entry;
	logic [15:0]         gain_q;

	// Gain register, written on each cfg transaction
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= yhh_pkg::GAIN_RESET;
		end else if (cfg.valid) begin
			gain_q <= cfg.data;
		end
	end

	yhh_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.push   (push),
		.entry  (wr_entry),
		.full   (full)
	);

	yhh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (full),
		.pop      (pop),
		.rd_entry (rd_entry),
		.empty    (empty)
	);

	yhh_back #(
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (rd_entry),
		.empty  (empty),
		.pop    (pop),
		.gain   (gain_q),
		.result (result)
	);

endmodule
